[rtl/vra_pkg.sv]
// ----------------------------------------------------------------------------
// vra_pkg
// Shared widths, latencies, constants and the CORDIC arctangent table for
// the axis-angle vector rotation pipeline.
// ----------------------------------------------------------------------------
package vra_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    localparam int IN_W   = 16;
    localparam int CX_W   = 33;
    localparam int CZ_W   = 34;
    localparam int NORM_W = 52;
    localparam int MAG_W  = 25;
    localparam int SQ_W   = 64;
    localparam int MOD_W  = 32;
    localparam int DIV_W  = 48;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int NORM_LAT   = 7 + SQRT_STEPS + DIV_STEPS;

    localparam int ONE_Q14 = 16384;

    localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef logic signed [NORM_W-1:0] norm_elem_t;
    typedef logic signed [IN_W-1:0]   unit_elem_t;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/vra_cordic_cell.sv]
// ----------------------------------------------------------------------------
// vra_cordic_cell
// One rotation-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
module vra_cordic_cell (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [4:0]                    idx,
    input  logic signed [vra_pkg::CX_W-1:0] x_in,
    input  logic signed [vra_pkg::CX_W-1:0] y_in,
    input  logic signed [vra_pkg::CZ_W-1:0] z_in,
    input  logic                          flag_in,
    output logic signed [vra_pkg::CX_W-1:0] x_out,
    output logic signed [vra_pkg::CX_W-1:0] y_out,
    output logic signed [vra_pkg::CZ_W-1:0] z_out,
    output logic                          flag_out
);
    import vra_pkg::*;

    logic signed [CX_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] ang;

    assign dx  = y_in >>> idx;
    assign dy  = x_in >>> idx;
    assign ang = $signed({3'b000, atan_q30(idx)});

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_out <= flag_in;
            if (z_in >= 0) begin
                x_out <= x_in - dx;
                y_out <= y_in + dy;
                z_out <= z_in - ang;
            end else begin
                x_out <= x_in + dx;
                y_out <= y_in - dy;
                z_out <= z_in + ang;
            end
        end
    end

endmodule

[rtl/vra_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// vra_sqrt_cell
// One digit step of the bitwise integer square root, registered.
// ----------------------------------------------------------------------------
module vra_sqrt_cell (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [5:0]               bit_exp,
    input  logic [vra_pkg::SQ_W-1:0] num_in,
    input  logic [vra_pkg::SQ_W-1:0] res_in,
    output logic [vra_pkg::SQ_W-1:0] num_out,
    output logic [vra_pkg::SQ_W-1:0] res_out
);
    import vra_pkg::*;

    logic [SQ_W-1:0] bitv, trial;

    assign bitv  = SQ_W'(1) << bit_exp;
    assign trial = res_in + bitv;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (num_in >= trial) begin
                num_out <= num_in - trial;
                res_out <= (res_in >> 1) + bitv;
            end else begin
                num_out <= num_in;
                res_out <= res_in >> 1;
            end
        end
    end

endmodule

[rtl/vra_div_cell.sv]
// ----------------------------------------------------------------------------
// vra_div_cell
// One quotient bit of a restoring divider, registered.
// ----------------------------------------------------------------------------
module vra_div_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [4:0]                     k,
    input  logic [vra_pkg::DIV_W-1:0]      rem_in,
    input  logic [vra_pkg::DIV_STEPS-1:0]  quo_in,
    input  logic [vra_pkg::MOD_W-1:0]      den_in,
    output logic [vra_pkg::DIV_W-1:0]      rem_out,
    output logic [vra_pkg::DIV_STEPS-1:0]  quo_out,
    output logic [vra_pkg::MOD_W-1:0]      den_out
);
    import vra_pkg::*;

    logic [DIV_W-1:0] trial;

    assign trial = DIV_W'(den_in) << k;

    always_ff @(posedge aclk) begin
        if (en) begin
            den_out <= den_in;
            if (rem_in >= trial) begin
                rem_out <= rem_in - trial;
                quo_out <= {quo_in[DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_out <= rem_in;
                quo_out <= {quo_in[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

endmodule

[rtl/vra_norm.sv]
// ----------------------------------------------------------------------------
// vra_norm
// Pipelined unit-vector normalizer: scale to a fixed magnitude window,
// sum of squares, square root and divide chains, Q2.14 result.
// ----------------------------------------------------------------------------
module vra_norm (
    input  logic                 aclk,
    input  logic                 en,
    input  vra_pkg::norm_elem_t  vin  [3],
    output vra_pkg::unit_elem_t  vout [3]
);
    import vra_pkg::*;

    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] WIN_LO = POS_W'(23);
    localparam logic [POS_W-1:0] WIN_HI = POS_W'(24);

    // magnitude and max
    logic [NORM_W-1:0] abs_v [3];
    logic [NORM_W-1:0] mx;
    logic [NORM_W-1:0] mag0_reg [3];
    logic [NORM_W-1:0] m0_reg;
    logic [2:0]        sgn0_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_v[i] = vin[i][NORM_W-1] ? NORM_W'(-vin[i]) : NORM_W'(vin[i]);
        end
        mx = abs_v[0];
        if (abs_v[1] > mx) mx = abs_v[1];
        if (abs_v[2] > mx) mx = abs_v[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg <= abs_v;
            m0_reg   <= mx;
            for (int i = 0; i < 3; i++) sgn0_reg[i] <= vin[i][NORM_W-1];
        end
    end

    // leading one
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos1_reg;
    logic [NORM_W-1:0] mag1_reg [3];
    logic [2:0]        sgn1_reg;
    logic              zero1_reg;

    always_comb begin
        pos_next = '0;
        for (int b = 0; b < NORM_W; b++) begin
            if (m0_reg[b]) pos_next = POS_W'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos1_reg  <= pos_next;
            mag1_reg  <= mag0_reg;
            sgn1_reg  <= sgn0_reg;
            zero1_reg <= (m0_reg == '0);
        end
    end

    // scale into the window, rounding when shifting down
    logic [MAG_W-1:0]  mag2_next [3];
    logic [MAG_W-1:0]  mag2_reg [3];
    logic [2:0]        sgn2_reg;
    logic              zero2_reg;

    always_comb begin
        logic [POS_W-1:0]  sh_up, sh_dn;
        logic [NORM_W:0]   bias, acc;
        sh_up = '0;
        sh_dn = '0;
        bias  = '0;
        acc   = '0;
        for (int i = 0; i < 3; i++) begin
            if (pos1_reg >= WIN_HI) begin
                sh_dn = pos1_reg - WIN_LO;
                bias  = (NORM_W+1)'(1) << (sh_dn - POS_W'(1));
                acc   = ({1'b0, mag1_reg[i]} + bias) >> sh_dn;
                mag2_next[i] = acc[MAG_W-1:0];
            end else begin
                sh_up = WIN_LO - pos1_reg;
                mag2_next[i] = MAG_W'(mag1_reg[i] << sh_up);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag2_reg  <= mag2_next;
            sgn2_reg  <= sgn1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // squares
    logic [2*MAG_W-1:0] sq3_reg [3];
    logic [MAG_W-1:0]   mag3_reg [3];
    logic [2:0]         sgn3_reg;
    logic               zero3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) sq3_reg[i] <= mag2_reg[i] * mag2_reg[i];
            mag3_reg  <= mag2_reg;
            sgn3_reg  <= sgn2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // sum of squares, scaled by 2^12
    logic [SQ_W-1:0]  num4_reg;
    logic [MAG_W-1:0] mag4_reg [3];
    logic [2:0]       sgn4_reg;
    logic             zero4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg  <= (SQ_W'(sq3_reg[0]) + SQ_W'(sq3_reg[1]) + SQ_W'(sq3_reg[2])) << 12;
            mag4_reg  <= mag3_reg;
            sgn4_reg  <= sgn3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // square root chain, sideband held alongside
    logic [SQ_W-1:0]  num_s [SQRT_STEPS+1];
    logic [SQ_W-1:0]  res_s [SQRT_STEPS+1];
    logic [MAG_W-1:0] magd_reg [SQRT_STEPS][3];
    logic [2:0]       sgnd_reg [SQRT_STEPS];
    logic             zerod_reg [SQRT_STEPS];

    assign num_s[0] = num4_reg;
    assign res_s[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        vra_sqrt_cell u_cell (
            .aclk    (aclk),
            .en      (en),
            .bit_exp (6'(2 * (SQRT_STEPS - 1 - k))),
            .num_in  (num_s[k]),
            .res_in  (res_s[k]),
            .num_out (num_s[k+1]),
            .res_out (res_s[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            magd_reg[0]  <= mag4_reg;
            sgnd_reg[0]  <= sgn4_reg;
            zerod_reg[0] <= zero4_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                magd_reg[k]  <= magd_reg[k-1];
                sgnd_reg[k]  <= sgnd_reg[k-1];
                zerod_reg[k] <= zerod_reg[k-1];
            end
        end
    end

    // dividend with half divisor for round-to-nearest
    logic [MOD_W-1:0] modv;
    logic [DIV_W-1:0] rem_p_reg [3];
    logic [MOD_W-1:0] den_p_reg;
    logic [2:0]       sgnp_reg;
    logic             zerop_reg;

    assign modv = res_s[SQRT_STEPS][MOD_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_p_reg[i] <= (DIV_W'(magd_reg[SQRT_STEPS-1][i]) << 20)
                              + DIV_W'(modv >> 1);
            end
            den_p_reg <= modv;
            sgnp_reg  <= sgnd_reg[SQRT_STEPS-1];
            zerop_reg <= zerod_reg[SQRT_STEPS-1];
        end
    end

    // divide chains, one per component
    logic [DIV_W-1:0]     rem_s [3][DIV_STEPS+1];
    logic [DIV_STEPS-1:0] quo_s [3][DIV_STEPS+1];
    logic [MOD_W-1:0]     den_s [3][DIV_STEPS+1];
    logic [2:0]           sgnq_reg [DIV_STEPS];
    logic                 zeroq_reg [DIV_STEPS];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_s[l][0] = rem_p_reg[l];
        assign quo_s[l][0] = '0;
        assign den_s[l][0] = den_p_reg;
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
            vra_div_cell u_cell (
                .aclk    (aclk),
                .en      (en),
                .k       (5'(DIV_STEPS - 1 - j)),
                .rem_in  (rem_s[l][j]),
                .quo_in  (quo_s[l][j]),
                .den_in  (den_s[l][j]),
                .rem_out (rem_s[l][j+1]),
                .quo_out (quo_s[l][j+1]),
                .den_out (den_s[l][j+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sgnq_reg[0]  <= sgnp_reg;
            zeroq_reg[0] <= zerop_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                sgnq_reg[k]  <= sgnq_reg[k-1];
                zeroq_reg[k] <= zeroq_reg[k-1];
            end
        end
    end

    // saturate, apply sign, zero vector maps to +x
    logic [IN_W-1:0] qsat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qsat[i] = (quo_s[i][DIV_STEPS] > DIV_STEPS'(ONE_Q14))
                    ? IN_W'(ONE_Q14) : quo_s[i][DIV_STEPS][IN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (zeroq_reg[DIV_STEPS-1]) begin
                    vout[i] <= (i == 0) ? IN_W'(ONE_Q14) : '0;
                end else if (sgnq_reg[DIV_STEPS-1][i]) begin
                    vout[i] <= -$signed(qsat[i]);
                end else begin
                    vout[i] <= $signed(qsat[i]);
                end
            end
        end
    end

endmodule

[rtl/vector_rotate_axis_angle.sv]
// ----------------------------------------------------------------------------
// vector_rotate_axis_angle
// Rotates a vector about an axis by an angle through the half-angle
// quaternion product q*v*conj(q) and returns the unit rotated vector.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                               | format
//  ---------+-----------+---------------------------------------+-------
//  s_       | in        | vec_x/y/z, axis_x/y/z, angle          | Q4.12
//  m_       | out       | rot_x/y/z                             | Q2.14
//
//  One transfer in and one transfer out per cycle, sustained while m_ready
//  is held high. Each normalizer is a chain of 32 square-root cells and
//  17 divide cells per component; the CORDIC chain runs beside the axis
//  normalizer and is padded to match it.
//  Reset clears only the valid line; payload registers are not reset.
//  A stall on m_ready freezes the whole chain; the last stage is the
//  output register, so s_ready follows it in the same cycle.
// ----------------------------------------------------------------------------
module vector_rotate_axis_angle (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_vec_x,
    input  logic signed [15:0] s_vec_y,
    input  logic signed [15:0] s_vec_z,
    input  logic signed [15:0] s_axis_x,
    input  logic signed [15:0] s_axis_y,
    input  logic signed [15:0] s_axis_z,
    input  logic signed [15:0] s_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_rot_x,
    output logic signed [15:0] m_rot_y,
    output logic signed [15:0] m_rot_z
);
    import vra_pkg::*;

    localparam int CS_W      = 19;
    localparam int W_W       = 19;
    localparam int PV_W      = CS_W + IN_W;
    localparam int P_W       = 38;
    localparam int RP_W      = P_W + W_W;
    localparam int R_W       = 60;
    localparam int CS_DLY    = NORM_LAT - CORDIC_N - 2;
    localparam int TOTAL_LAT = 2 * NORM_LAT + 5;

    // round to nearest, ties away from zero, after dropping 14 bits
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        logic signed [63:0] a;
        a = (v < 0) ? -v : v;
        a = (a + 64'sd8192) >>> 14;
        return (v < 0) ? -a : a;
    endfunction

    logic en;
    logic [TOTAL_LAT-1:0] vld_reg;

    // advance everything unless the output holds an untaken result
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_valid};
        end
    end

    // axis normalizer
    norm_elem_t axis_in [3];
    unit_elem_t unit_ax [3];

    assign axis_in[0] = NORM_W'(s_axis_x);
    assign axis_in[1] = NORM_W'(s_axis_y);
    assign axis_in[2] = NORM_W'(s_axis_z);

    vra_norm u_axis_norm (
        .aclk (aclk),
        .en   (en),
        .vin  (axis_in),
        .vout (unit_ax)
    );

    // half angle, folded into [-pi/2, pi/2]
    logic signed [CZ_W-1:0] za;
    logic signed [CZ_W-1:0] z0_reg;
    logic                   neg0_reg;

    assign za = CZ_W'(s_angle) <<< 17;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (za > HALF_PI_Q30) begin
                z0_reg   <= za - PI_Q30;
                neg0_reg <= 1'b1;
            end else if (za < -HALF_PI_Q30) begin
                z0_reg   <= za + PI_Q30;
                neg0_reg <= 1'b1;
            end else begin
                z0_reg   <= za;
                neg0_reg <= 1'b0;
            end
        end
    end

    // CORDIC chain; gain is left in, the final normalizer removes it
    logic signed [CX_W-1:0] cx_s [CORDIC_N+1];
    logic signed [CX_W-1:0] cy_s [CORDIC_N+1];
    logic signed [CZ_W-1:0] cz_s [CORDIC_N+1];
    logic                   cf_s [CORDIC_N+1];

    assign cx_s[0] = CX_W'(64'sd1073741824);
    assign cy_s[0] = '0;
    assign cz_s[0] = z0_reg;
    assign cf_s[0] = neg0_reg;

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
        vra_cordic_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .idx      (5'(i)),
            .x_in     (cx_s[i]),
            .y_in     (cy_s[i]),
            .z_in     (cz_s[i]),
            .flag_in  (cf_s[i]),
            .x_out    (cx_s[i+1]),
            .y_out    (cy_s[i+1]),
            .z_out    (cz_s[i+1]),
            .flag_out (cf_s[i+1])
        );
    end

    // cosine and sine to Q.16, undo the fold
    logic signed [CS_W-1:0] c_rnd, s_rnd;
    logic signed [CS_W-1:0] cr_reg, sr_reg;

    assign c_rnd = CS_W'(rnd14(64'(cx_s[CORDIC_N])));
    assign s_rnd = CS_W'(rnd14(64'(cy_s[CORDIC_N])));

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_reg <= cf_s[CORDIC_N] ? -c_rnd : c_rnd;
            sr_reg <= cf_s[CORDIC_N] ? -s_rnd : s_rnd;
        end
    end

    // align cosine, sine and the vector with the unit axis
    logic signed [CS_W-1:0] cd_reg [CS_DLY];
    logic signed [CS_W-1:0] sd_reg [CS_DLY];
    logic signed [IN_W-1:0] vd_reg [NORM_LAT][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_reg[0]    <= cr_reg;
            sd_reg[0]    <= sr_reg;
            vd_reg[0][0] <= s_vec_x;
            vd_reg[0][1] <= s_vec_y;
            vd_reg[0][2] <= s_vec_z;
            for (int k = 1; k < CS_DLY; k++) begin
                cd_reg[k] <= cd_reg[k-1];
                sd_reg[k] <= sd_reg[k-1];
            end
            for (int k = 1; k < NORM_LAT; k++) vd_reg[k] <= vd_reg[k-1];
        end
    end

    // q1: quaternion vector part w = s*u, rounded back to Q.16
    logic signed [PV_W-1:0] su [3];
    logic signed [W_W-1:0]  w1_reg [3];
    logic signed [CS_W-1:0] c1_reg;
    logic signed [IN_W-1:0] v1_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) su[i] = sd_reg[CS_DLY-1] * unit_ax[i];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) w1_reg[i] <= W_W'(rnd14(64'(su[i])));
            c1_reg <= cd_reg[CS_DLY-1];
            v1_reg <= vd_reg[NORM_LAT-1];
        end
    end

    // q2: products of q with (0, v)
    logic signed [PV_W-1:0] wv2_reg [3][3];
    logic signed [PV_W-1:0] cv2_reg [3];
    logic signed [W_W-1:0]  w2_reg [3];
    logic signed [CS_W-1:0] c2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) wv2_reg[i][j] <= w1_reg[i] * v1_reg[j];
                cv2_reg[i] <= c1_reg * v1_reg[i];
            end
            w2_reg <= w1_reg;
            c2_reg <= c1_reg;
        end
    end

    // q3: p = q * (0, v)
    logic signed [P_W-1:0]  p3_reg [4];
    logic signed [W_W-1:0]  w3_reg [3];
    logic signed [CS_W-1:0] c3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_reg[0] <= -(P_W'(wv2_reg[0][0]) + P_W'(wv2_reg[1][1]) + P_W'(wv2_reg[2][2]));
            p3_reg[1] <= P_W'(cv2_reg[0]) + P_W'(wv2_reg[1][2]) - P_W'(wv2_reg[2][1]);
            p3_reg[2] <= P_W'(cv2_reg[1]) + P_W'(wv2_reg[2][0]) - P_W'(wv2_reg[0][2]);
            p3_reg[3] <= P_W'(cv2_reg[2]) + P_W'(wv2_reg[0][1]) - P_W'(wv2_reg[1][0]);
            w3_reg    <= w2_reg;
            c3_reg    <= c2_reg;
        end
    end

    // q4: products of p with conj(q)
    logic signed [RP_W-1:0] pw4_reg [4][3];
    logic signed [RP_W-1:0] cp4_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) pw4_reg[i][j] <= p3_reg[i] * w3_reg[j];
            end
            for (int j = 0; j < 3; j++) cp4_reg[j] <= c3_reg * p3_reg[j+1];
        end
    end

    // q5: vector part of p * conj(q)
    logic signed [R_W-1:0] r_sum [3];
    norm_elem_t            r5_reg [3];

    always_comb begin
        r_sum[0] = -R_W'(pw4_reg[0][0]) + R_W'(cp4_reg[0])
                 -  R_W'(pw4_reg[2][2]) + R_W'(pw4_reg[3][1]);
        r_sum[1] = -R_W'(pw4_reg[0][1]) + R_W'(cp4_reg[1])
                 -  R_W'(pw4_reg[3][0]) + R_W'(pw4_reg[1][2]);
        r_sum[2] = -R_W'(pw4_reg[0][2]) + R_W'(cp4_reg[2])
                 -  R_W'(pw4_reg[1][1]) + R_W'(pw4_reg[2][0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) r5_reg[i] <= r_sum[i][NORM_W-1:0];
        end
    end

    // result normalizer; its output register is the m_ channel register
    unit_elem_t rot [3];

    vra_norm u_rot_norm (
        .aclk (aclk),
        .en   (en),
        .vin  (r5_reg),
        .vout (rot)
    );

    assign m_rot_x = rot[0];
    assign m_rot_y = rot[1];
    assign m_rot_z = rot[2];

endmodule
